// ===== src/otb_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and unit interfaces of the threshold binarizer.
package otb_pkg;

   localparam int GRAY_W     = 5;
   localparam int LEVELS     = 1 << GRAY_W;
   localparam int PIXEL_W    = 16;
   localparam int MAX_PIXELS = 131072;

   // A bin or the pixel count must hold MAX_PIXELS itself.
   localparam int COUNT_W    = $clog2(MAX_PIXELS + 1);
   localparam int SUM_W      = COUNT_W + GRAY_W;
   localparam int DIV_STEP_W = $clog2(GRAY_W);

   // Shared multiplier: operand a carries up to count1*count2, operand b at most a count's width.
   // The widest product is count1*count2*(mean difference squared).
   localparam int MUL_A_W    = 2 * COUNT_W;
   localparam int MUL_B_W    = COUNT_W;
   localparam int PROD_W     = 2 * COUNT_W + 2 * GRAY_W;

   localparam logic [PIXEL_W-1:0] GRAY_MASK  = 16'h001F;
   localparam logic [PIXEL_W-1:0] BLACK_WORD = 16'h0000;
   localparam logic [PIXEL_W-1:0] WHITE_WORD = 16'hFFFF;

   localparam logic KIND_ACCUMULATE = 1'b0;
   localparam logic KIND_BINARIZE   = 1'b1;
   localparam logic RESULT_REPORT   = 1'b0;
   localparam logic RESULT_PIXEL    = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SUMS,
      ST_DIV1,
      ST_DIV2,
      ST_SQR,
      ST_NPROD,
      ST_SCORE,
      ST_CMP,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic               start;
      logic [SUM_W-1:0]   num;
      logic [COUNT_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [GRAY_W-1:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_op_type;

endpackage

// ===== src/otsu_threshold_binarizer_top.sv =====
`timescale 1ns / 1ps
// Accumulate words are taken back to back while the output register can take a word.
// A binarize word shows its result in the cycle after acceptance, through an output register.
// A last accumulate word starts a search of 32 thresholds, each with two five-step
// divisions, and the report follows once the search is through.
// Synchronous reset clears the histogram valid bits, counters, flags and the sequencer.
module otsu_threshold_binarizer_top import otb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic [PIXEL_W-1:0] req_pixel,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_result_kind,
   output logic [GRAY_W-1:0]  rsp_threshold,
   output logic [PIXEL_W-1:0] rsp_binary_pixel,
   output logic               rsp_frame_too_large
);

   state_type state_ff, state_in;

   // Frame totals and search registers.
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic                overflow_ff, overflow_in;
   logic [GRAY_W-1:0]   stored_thr_ff, stored_thr_in;
   logic [GRAY_W-1:0]   t_ff, t_in;
   logic [COUNT_W-1:0]  n1_ff, n1_in;
   logic [SUM_W-1:0]    s1_ff, s1_in;
   logic [GRAY_W-1:0]   m1_ff, m1_in;
   logic [GRAY_W-1:0]   m2_ff, m2_in;
   logic [2*GRAY_W-1:0] dd_ff, dd_in;
   logic [PROD_W-1:0]   best_ff, best_in;
   logic [GRAY_W-1:0]   best_t_ff, best_t_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic [GRAY_W-1:0]  rsp_thr_ff, rsp_thr_in;
   logic [PIXEL_W-1:0] rsp_pix_ff, rsp_pix_in;
   logic               rsp_ftl_ff, rsp_ftl_in;

   logic               out_free;
   logic               req_fire;
   logic [PIXEL_W-1:0] gray_word;
   logic [GRAY_W-1:0]  gray;
   logic [GRAY_W-1:0]  diff;
   logic [COUNT_W-1:0] n2;

   logic               hist_clear;
   logic               hist_inc;
   logic [COUNT_W-1:0] hist_rd;

   mul_op_type         mul_op;
   logic [PROD_W-1:0]  mul_prod;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   otb_hist u_hist (
      .clock    (clock),
      .reset    (reset),
      .clear    (hist_clear),
      .inc_en   (hist_inc),
      .inc_addr (gray),
      .rd_addr  (t_ff),
      .rd_data  (hist_rd)
   );

   otb_mul u_mul (
      .clock (clock),
      .op    (mul_op),
      .prod  (mul_prod)
   );

   otb_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // The output register can take a new word when it is empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign req_fire  = req_valid && !req_stall;

   assign gray_word = req_pixel & GRAY_MASK;
   assign gray      = gray_word[GRAY_W-1:0];
   assign diff      = (m1_ff > m2_ff) ? (m1_ff - m2_ff) : (m2_ff - m1_ff);
   assign n2        = count_ff - n1_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_kind == KIND_ACCUMULATE) && req_last) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD:  state_in = ST_SUMS;
         ST_SUMS:  state_in = ST_DIV1;
         ST_DIV1: begin
            if (div_rsp.done) begin
               state_in = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (div_rsp.done) begin
               state_in = ST_SQR;
            end
         end
         ST_SQR:   state_in = ST_NPROD;
         ST_NPROD: state_in = ST_SCORE;
         ST_SCORE: state_in = ST_CMP;
         ST_CMP: begin
            if (t_ff == GRAY_W'(LEVELS - 1)) begin
               state_in = ST_REPORT;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_REPORT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath control and next register values.
   always_comb begin
      count_in      = count_ff;
      sum_in        = sum_ff;
      overflow_in   = overflow_ff;
      stored_thr_in = stored_thr_ff;
      t_in          = t_ff;
      n1_in         = n1_ff;
      s1_in         = s1_ff;
      m1_in         = m1_ff;
      m2_in         = m2_ff;
      dd_in         = dd_ff;
      best_in       = best_ff;
      best_t_in     = best_t_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_thr_in    = rsp_thr_ff;
      rsp_pix_in    = rsp_pix_ff;
      rsp_ftl_in    = rsp_ftl_ff;
      hist_clear    = 1'b0;
      hist_inc      = 1'b0;
      mul_op        = '0;
      div_req       = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_kind == KIND_BINARIZE) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = RESULT_PIXEL;
                  rsp_thr_in   = stored_thr_ff;
                  rsp_pix_in   = (gray < stored_thr_ff) ? BLACK_WORD : WHITE_WORD;
                  rsp_ftl_in   = overflow_ff;
               end else begin
                  // Words past capacity are dropped and only flagged.
                  if (count_ff < COUNT_W'(MAX_PIXELS)) begin
                     hist_inc = 1'b1;
                     count_in = count_ff + 1'b1;
                     sum_in   = sum_ff + SUM_W'(gray);
                  end else begin
                     overflow_in = 1'b1;
                  end
                  if (req_last) begin
                     t_in      = '0;
                     n1_in     = '0;
                     s1_in     = '0;
                     best_in   = '0;
                     best_t_in = '0;
                  end
               end
            end
         end
         ST_LOAD: begin
            // Class 1 grows by bin t; its level sum picks up bin*t next cycle.
            n1_in    = n1_ff + hist_rd;
            mul_op.a = MUL_A_W'(hist_rd);
            mul_op.b = MUL_B_W'(t_ff);
         end
         ST_SUMS: begin
            s1_in         = s1_ff + mul_prod[SUM_W-1:0];
            div_req.start = 1'b1;
            div_req.num   = s1_in;
            div_req.den   = n1_ff;
         end
         ST_DIV1: begin
            if (div_rsp.done) begin
               m1_in         = div_rsp.quot;
               div_req.start = 1'b1;
               div_req.num   = sum_ff - s1_ff;
               div_req.den   = n2;
            end
         end
         ST_DIV2: begin
            if (div_rsp.done) begin
               m2_in = div_rsp.quot;
            end
         end
         ST_SQR: begin
            mul_op.a = MUL_A_W'(diff);
            mul_op.b = MUL_B_W'(diff);
         end
         ST_NPROD: begin
            dd_in    = mul_prod[2*GRAY_W-1:0];
            mul_op.a = MUL_A_W'(n1_ff);
            mul_op.b = n2;
         end
         ST_SCORE: begin
            mul_op.a = mul_prod[MUL_A_W-1:0];
            mul_op.b = MUL_B_W'(dd_ff);
         end
         ST_CMP: begin
            // Only a strictly larger score moves the choice, so the first maximum wins.
            if (mul_prod > best_ff) begin
               best_in   = mul_prod;
               best_t_in = t_ff;
            end
            t_in = t_ff + 1'b1;
         end
         ST_REPORT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = RESULT_REPORT;
               rsp_thr_in    = best_t_ff;
               rsp_pix_in    = BLACK_WORD;
               rsp_ftl_in    = overflow_ff;
               stored_thr_in = best_t_ff;
               count_in      = '0;
               sum_in        = '0;
               overflow_in   = 1'b0;
               hist_clear    = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         sum_ff        <= '0;
         overflow_ff   <= 1'b0;
         stored_thr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         overflow_ff   <= overflow_in;
         stored_thr_ff <= stored_thr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff        <= t_in;
      n1_ff       <= n1_in;
      s1_ff       <= s1_in;
      m1_ff       <= m1_in;
      m2_ff       <= m2_in;
      dd_ff       <= dd_in;
      best_ff     <= best_in;
      best_t_ff   <= best_t_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_thr_ff  <= rsp_thr_in;
      rsp_pix_ff  <= rsp_pix_in;
      rsp_ftl_ff  <= rsp_ftl_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = rsp_kind_ff;
   assign rsp_threshold       = rsp_thr_ff;
   assign rsp_binary_pixel    = rsp_pix_ff;
   assign rsp_frame_too_large = rsp_ftl_ff;

endmodule

// ===== src/otb_hist.sv =====
`timescale 1ns / 1ps
// Gray-level histogram with per-bin valid bits, so a clear empties every bin at once.
module otb_hist import otb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               clear,
   input  logic               inc_en,
   input  logic [GRAY_W-1:0]  inc_addr,
   input  logic [GRAY_W-1:0]  rd_addr,
   output logic [COUNT_W-1:0] rd_data
);

   logic [LEVELS-1:0]  valid_ff;
   logic [LEVELS-1:0]  valid_in;
   logic [COUNT_W-1:0] count_ff [LEVELS];
   logic [COUNT_W-1:0] count_in;
   logic [GRAY_W-1:0]  addr;
   logic [COUNT_W-1:0] cur;

   // The increment and the search never run in the same cycle, so one port serves both.
   assign addr    = inc_en ? inc_addr : rd_addr;
   assign cur     = valid_ff[addr] ? count_ff[addr] : '0;
   assign rd_data = cur;
   assign count_in = cur + 1'b1;

   always_comb begin
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end else if (inc_en) begin
         valid_in[addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (inc_en) begin
         count_ff[addr] <= count_in;
      end
   end

endmodule

// ===== src/otb_mul.sv =====
`timescale 1ns / 1ps
// Shared multiplier with a registered product.
module otb_mul import otb_pkg::*; (
   input  logic              clock,
   input  mul_op_type        op,
   output logic [PROD_W-1:0] prod
);

   logic [MUL_A_W+MUL_B_W-1:0] full;
   logic [PROD_W-1:0]          prod_ff;
   logic [PROD_W-1:0]          prod_in;

   assign full    = op.a * op.b;
   // Every product the sequencer forms fits in PROD_W bits.
   assign prod_in = full[PROD_W-1:0];
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== src/otb_div.sv =====
`timescale 1ns / 1ps
// Restoring divider that yields a class mean, one quotient bit per cycle.
module otb_div import otb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [SUM_W-1:0]      rem_ff, rem_in;
   logic [COUNT_W-1:0]    den_ff, den_in;
   logic [GRAY_W-1:0]     q_ff, q_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [SUM_W-1:0]      den_sh;

   // A class mean never exceeds the top gray level, so GRAY_W quotient bits suffice.
   assign den_sh = {{(SUM_W-COUNT_W){1'b0}}, den_ff} << step_ff;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = req.num;
         den_in  = req.den;
         q_in    = '0;
         step_in = DIV_STEP_W'(GRAY_W - 1);
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (rem_ff >= den_sh) begin
            rem_in        = rem_ff - den_sh;
            q_in[step_ff] = 1'b1;
         end
         if (step_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
      step_ff <= step_in;
   end

   // An empty class has mean zero.
   assign rsp.done = done_ff;
   assign rsp.quot = (den_ff == '0) ? '0 : q_ff;

endmodule

// ===== tb/otsu_threshold_binarizer_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Otsu threshold binarizer: directed and random tests.
module otsu_threshold_binarizer_top_tb import otb_pkg::*;;

   // Longest legal run of cycles without any accepted word. It lies well above both
   // the threshold search and the long receiver hold-off, so this leaves
   // a wide margin over the slowest correct behavior.
   localparam int IDLE_LIMIT       = 8000;
   // Cycles allowed after the last expected word, about one threshold search.
   localparam int SEARCH_CYCLES    = 650;
   localparam int RANDOM_WORDS     = 2000;
   localparam int HOLDOFF_CYCLES   = 1500;
   localparam int SHOWN_MISMATCHES = 10;

   typedef struct packed {
      logic               result_kind;
      logic [GRAY_W-1:0]  threshold;
      logic [PIXEL_W-1:0] binary_pixel;
      logic               frame_too_large;
   } result_word_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_kind;
   logic [PIXEL_W-1:0] req_pixel;
   logic               req_last;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_result_kind;
   logic [GRAY_W-1:0]  rsp_threshold;
   logic [PIXEL_W-1:0] rsp_binary_pixel;
   logic               rsp_frame_too_large;

   // Our own copy of the block state, advanced once per accepted input word.
   longint unsigned   hist_bins [LEVELS];
   int unsigned       frame_pixels;
   logic [GRAY_W-1:0] thr_stored;
   logic              frame_overflow;

   // Results still owed by the block, oldest first.
   result_word_type   pending_results [$];
   int unsigned       errors;

   // When set, the sender inserts no idle cycles and the receiver stalls only for a hold-off.
   bit                quiet;
   // Set by a test to make the receiver hold off for that many cycles.
   int unsigned       holdoff_left;

   otsu_threshold_binarizer_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_pixel           (req_pixel),
      .req_last            (req_last),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_threshold       (rsp_threshold),
      .rsp_binary_pixel    (rsp_binary_pixel),
      .rsp_frame_too_large (rsp_frame_too_large)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Exhaustive Otsu search over the current histogram. Class 1 holds the levels
   // up to and including t, class 2 the levels above it. Means are truncated and
   // an empty class has mean 0. The first strictly larger score wins, so a frame
   // whose scores are all zero picks threshold 0.
   function automatic logic [GRAY_W-1:0] otsu_pick_threshold();
      longint unsigned   tot_n, tot_s, n1, s1, n2, s2, m1, m2, d, score, best;
      logic [GRAY_W-1:0] best_t;
      tot_n  = 0;
      tot_s  = 0;
      n1     = 0;
      s1     = 0;
      best   = 0;
      best_t = '0;
      for (int t = 0; t < LEVELS; t++) begin
         tot_n += hist_bins[t];
         tot_s += hist_bins[t] * longint'(t);
      end
      for (int t = 0; t < LEVELS; t++) begin
         n1 += hist_bins[t];
         s1 += hist_bins[t] * longint'(t);
         n2 = tot_n - n1;
         s2 = tot_s - s1;
         m1 = (n1 != 0) ? s1 / n1 : 0;
         m2 = (n2 != 0) ? s2 / n2 : 0;
         d  = (m1 > m2) ? m1 - m2 : m2 - m1;
         score = n1 * n2 * d * d;
         if (score > best) begin
            best   = score;
            best_t = GRAY_W'(t);
         end
      end
      return best_t;
   endfunction

   function automatic void clear_frame();
      foreach (hist_bins[i]) hist_bins[i] = 0;
      frame_pixels   = 0;
      frame_overflow = 1'b0;
   endfunction

   // Advances the predicted state by one accepted word and queues its result.
   function automatic void binarizer_predict(logic kind, logic [PIXEL_W-1:0] pixel,
                                             logic last);
      logic [GRAY_W-1:0] gray;
      result_word_type   r;
      gray = GRAY_W'(pixel & GRAY_MASK);
      if (kind == KIND_BINARIZE) begin
         // The last flag means nothing on a binarize word.
         r.result_kind     = RESULT_PIXEL;
         r.threshold       = thr_stored;
         r.binary_pixel    = (gray < thr_stored) ? BLACK_WORD : WHITE_WORD;
         r.frame_too_large = frame_overflow;
         pending_results.push_back(r);
      end else begin
         // A full frame drops further pixels and remembers that it did.
         if (frame_pixels < MAX_PIXELS) begin
            hist_bins[gray]++;
            frame_pixels++;
         end else begin
            frame_overflow = 1'b1;
         end
         if (last) begin
            thr_stored        = otsu_pick_threshold();
            r.result_kind     = RESULT_REPORT;
            r.threshold       = thr_stored;
            r.binary_pixel    = '0;
            r.frame_too_large = frame_overflow;
            pending_results.push_back(r);
            clear_frame();
         end
      end
   endfunction

   function automatic void flag_error(string msg);
      errors++;
      if (errors <= SHOWN_MISMATCHES) $display("ERROR at %0t: %s", $realtime, msg);
   endfunction

   // Mostly short gaps, sometimes a long one, none in quiet stretches.
   function automatic int unsigned gap_len();
      int unsigned roll;
      roll = $urandom_range(99, 0);
      if (quiet) return 0;
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Random upper bits around a chosen gray level, so every pixel bit toggles.
   function automatic logic [PIXEL_W-1:0] pixel_of(logic [GRAY_W-1:0] gray);
      logic [PIXEL_W-1:0] pixel;
      pixel = PIXEL_W'($urandom);
      pixel[GRAY_W-1:0] = gray;
      return pixel;
   endfunction

   // Offers one word and returns right after the edge that accepted it. Inputs
   // move only at falling edges. Valid is lowered only when a gap follows, so it
   // is never lowered and raised again at the same edge.
   task automatic send_word(logic kind, logic [PIXEL_W-1:0] pixel, logic last);
      int unsigned gap;
      gap = gap_len();
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_pixel <= pixel;
      req_last  <= last;
      do @(posedge clock); while (req_stall !== 1'b0);
      binarizer_predict(kind, pixel, last);
   endtask

   // Stops offering words and waits until the block owes nothing more.
   task automatic drain_results(int unsigned settle);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Straight after reset the stored threshold is 0, so every pixel is white.
   // The last flag on a binarize word must be ignored.
   task automatic test_reset_state();
      send_word(KIND_BINARIZE, 16'h0000, 1'b0);
      send_word(KIND_BINARIZE, 16'hFFFF, 1'b1);
      send_word(KIND_BINARIZE, 16'hFFE0, 1'b0);
      send_word(KIND_BINARIZE, 16'h001F, 1'b1);
      drain_results(4);
   endtask

   // A single-pixel frame and a single-level frame both score zero everywhere.
   task automatic test_flat_frames();
      send_word(KIND_ACCUMULATE, 16'hFFFF, 1'b1);
      send_word(KIND_BINARIZE, 16'h0000, 1'b0);
      for (int i = 0; i < 4; i++) send_word(KIND_ACCUMULATE, 16'hA5B1, i == 3);
      send_word(KIND_BINARIZE, 16'h0010, 1'b0);
      drain_results(4);
   endtask

   // Two extreme levels give a clear split; binarize around both ends of it.
   // Pixels with all upper bits set check that only the low five bits count.
   task automatic test_two_level_frame();
      for (int i = 0; i < 3; i++) send_word(KIND_ACCUMULATE, 16'hFFE0, 1'b0);
      for (int i = 0; i < 3; i++) send_word(KIND_ACCUMULATE, 16'h001F, i == 2);
      send_word(KIND_BINARIZE, 16'hFFE0, 1'b0);
      send_word(KIND_BINARIZE, 16'h001E, 1'b0);
      send_word(KIND_BINARIZE, 16'h0001, 1'b1);
      send_word(KIND_BINARIZE, 16'hFFFF, 1'b0);
      drain_results(4);
   endtask

   // The receiver holds off for a long stretch while words keep coming, so the
   // output fills and the block must stall its input. A second, shorter hold-off
   // starts with the threshold search and lands on its report.
   task automatic test_back_pressure();
      holdoff_left = HOLDOFF_CYCLES;
      quiet = 1'b1;
      for (int i = 0; i < 12; i++) send_word(KIND_BINARIZE, PIXEL_W'($urandom), 1'b0);
      for (int i = 0; i < 6; i++) send_word(KIND_ACCUMULATE, PIXEL_W'($urandom), i == 5);
      for (int i = 0; i < 4; i++) send_word(KIND_BINARIZE, PIXEL_W'($urandom), 1'b0);
      quiet = 1'b0;
      drain_results(4);
      for (int i = 0; i < 5; i++) send_word(KIND_ACCUMULATE, PIXEL_W'($urandom), i == 4);
      holdoff_left = HOLDOFF_CYCLES / 2;
      for (int i = 0; i < 5; i++) send_word(KIND_BINARIZE, PIXEL_W'($urandom), 1'b0);
      drain_results(4);
   endtask

   // Random frames of mixed shapes. Most frames are closed by a last pixel; a few
   // run on into the next one, and stray binarize words are mixed in.
   task automatic test_random_frames();
      int unsigned       sent, frame_len, shape, c_lo, c_hi, tail;
      bit                closes;
      logic [GRAY_W-1:0] gray;
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         quiet     = ($urandom_range(7, 0) == 0);
         shape     = $urandom_range(3, 0);
         c_lo      = $urandom_range(31, 0);
         c_hi      = $urandom_range(31, 0);
         closes    = ($urandom_range(7, 0) != 0);
         frame_len = ($urandom_range(9, 0) == 0) ? $urandom_range(400, 41)
                                                 : $urandom_range(40, 1);
         for (int i = 0; i < frame_len; i++) begin
            if ($urandom_range(9, 0) == 0) begin
               send_word(KIND_BINARIZE, PIXEL_W'($urandom), 1'($urandom_range(1, 0)));
               sent++;
            end
            case (shape)
               0: gray = GRAY_W'($urandom);
               1: gray = GRAY_W'(($urandom_range(1, 0) ? c_lo : c_hi)
                                 + $urandom_range(3, 0));
               2: gray = GRAY_W'(c_lo);
               default: gray = $urandom_range(1, 0) ? '1 : '0;
            endcase
            send_word(KIND_ACCUMULATE, pixel_of(gray), closes && i == frame_len - 1);
            sent++;
         end
         tail = $urandom_range(6, 0);
         for (int j = 0; j < tail; j++) begin
            send_word(KIND_BINARIZE, PIXEL_W'($urandom), 1'b0);
            sent++;
         end
      end
      quiet = 1'b0;
   endtask

   // Receiver: picks random runs of stall and no stall, honors a requested
   // hold-off first, and never stalls during quiet stretches.
   initial begin
      int unsigned run_left;
      bit          run_stalled;
      run_left    = 0;
      run_stalled = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_left != 0) begin
            rsp_stall <= 1'b1;
            holdoff_left--;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            if (run_left == 0) begin
               run_stalled = ($urandom_range(2, 0) == 0);
               run_left    = gap_len() + 1;
            end
            rsp_stall <= run_stalled;
            run_left--;
         end
      end
   end

   // Result checker: every accepted result word is matched with the oldest
   // expectation, field by field.
   initial begin
      result_word_type want;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
               flag_error($sformatf("unexpected result kind %0d thr %0d pix %h big %0d",
                  rsp_result_kind, rsp_threshold, rsp_binary_pixel, rsp_frame_too_large));
            end else begin
               want = pending_results.pop_front();
               if (rsp_result_kind !== want.result_kind || rsp_threshold !== want.threshold
                   || rsp_binary_pixel !== want.binary_pixel
                   || rsp_frame_too_large !== want.frame_too_large)
                  flag_error($sformatf(
                     "expected kind %0d thr %0d pix %h big %0d, got %0d %0d %h %0d",
                     want.result_kind, want.threshold, want.binary_pixel,
                     want.frame_too_large, rsp_result_kind, rsp_threshold,
                     rsp_binary_pixel, rsp_frame_too_large));
            end
         end
      end
   end

   // Watchdog: ends the run when no word moves on either side for too long.
   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset === 1'b1 || (req_valid === 1'b1 && req_stall === 1'b0)
             || (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Test sequence. Reset is held at the start and released once.
   initial begin
      errors       = 0;
      quiet        = 1'b0;
      holdoff_left = 0;
      thr_stored   = '0;
      clear_frame();
      req_valid <= 1'b0;
      req_kind  <= KIND_ACCUMULATE;
      req_pixel <= '0;
      req_last  <= 1'b0;
      reset     <= 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_flat_frames();
      test_two_level_frame();
      test_back_pressure();
      test_random_frames();

      // Give any trailing search time to finish; anything still owed is an error.
      drain_results(SEARCH_CYCLES);
      errors += pending_results.size();
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
